>>> hdl/assert_macros.svh
// Assertion helpers for the RTL files, included by aesgf_power_pipe.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/aesgf_pkg.sv
package aesgf_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] AFFINE_CONST = 8'h63;
    localparam logic [BYTE_W-1:0] REDUCE_CONST = 8'h1B;
    localparam logic [BYTE_W-1:0] TOP_BIT      = 8'h80;

    typedef logic [BYTE_W-1:0] gf_byte_t;

    // One pipeline beat handed between modules.
    typedef struct packed {
        logic     valid;
        gf_byte_t data;
    } pipe_beat_t;

    // Multiply by x modulo the field polynomial.
    function automatic gf_byte_t gf_double(input gf_byte_t v);
        gf_byte_t shifted;
        shifted = {v[BYTE_W-2:0], 1'b0};
        if ((v & TOP_BIT) != '0) begin
            shifted = shifted ^ REDUCE_CONST;
        end
        return shifted;
    endfunction

    // Field product, most significant bit of q first.
    function automatic gf_byte_t gf_mul(input gf_byte_t p, input gf_byte_t q);
        gf_byte_t acc;
        acc = '0;
        for (int bit_idx = BYTE_W - 1; bit_idx >= 0; bit_idx--) begin
            acc = gf_double(acc);
            if (q[bit_idx]) begin
                acc = acc ^ p;
            end
        end
        return acc;
    endfunction

    // AES affine transform of an inverse.
    function automatic gf_byte_t aes_affine(input gf_byte_t inv);
        gf_byte_t r1, r2, r3, r4;
        r1 = {inv[6:0], inv[7]};
        r2 = {inv[5:0], inv[7:6]};
        r3 = {inv[4:0], inv[7:5]};
        r4 = {inv[3:0], inv[7:4]};
        return inv ^ r1 ^ r2 ^ r3 ^ r4 ^ AFFINE_CONST;
    endfunction

endpackage

>>> hdl/aes_sbox_gf_inverse_unit.sv
// Computes the AES forward S-box of one byte per beat without a lookup table:
// the inverse in GF(2^8) is formed as the byte raised to the 254th power
// through eleven field multiplications, zero mapping to zero, followed by the
// AES affine transform. The unit takes a new byte every cycle while the output
// is not stalled. Each result passes through the five register stages of the
// multiplication chain, those of the power pipeline and then the output
// register, each stage holding at most two dependent field products; a stall
// on the output side fills the empty stages first and loses no beat.
module aes_sbox_gf_inverse_unit
    import aesgf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] sub_byte
);

    pipe_beat_t in_beat, mid_beat;
    logic       mid_ready;

    assign in_beat.valid = s_tvalid;
    assign in_beat.data  = s_tdata;

    // Power chain up to the 127th power.
    aesgf_power_pipe u_power (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (in_beat),
        .in_ready  (s_tready),
        .out_beat  (mid_beat),
        .out_ready (mid_ready)
    );

    // Last squaring, affine transform and output register.
    aesgf_affine_stage u_affine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (mid_beat),
        .in_ready  (mid_ready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_ready (m_tready)
    );

endmodule

>>> hdl/aesgf_power_pipe.sv
`include "assert_macros.svh"

module aesgf_power_pipe
    import aesgf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_beat_t in_beat,
    output logic       in_ready,
    output pipe_beat_t out_beat,
    input  logic       out_ready
);

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage payloads, named by the power of the input they hold.
    gf_byte_t e3_1_reg, e4_1_reg;
    gf_byte_t e7_2_reg, e15_2_reg;
    gf_byte_t e7_3_reg, e60_3_reg;
    gf_byte_t e127_4_reg;

    gf_byte_t e2_c, e7_c, e8_c, e30_c, e67_c;

    // A stage takes a beat when it is empty or its content moves on.
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_beat.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    // Products formed between the stage registers.
    always_comb begin
        e2_c  = gf_mul(in_beat.data, in_beat.data);
        e7_c  = gf_mul(e3_1_reg, e4_1_reg);
        e8_c  = gf_mul(e4_1_reg, e4_1_reg);
        e30_c = gf_mul(e15_2_reg, e15_2_reg);
        e67_c = gf_mul(e7_3_reg, e60_3_reg);
    end

    // Valid bits are control state and are reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Payloads load whenever their stage takes a beat.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            e3_1_reg <= gf_mul(e2_c, in_beat.data);
            e4_1_reg <= gf_mul(e2_c, e2_c);
        end
        if (rdy2) begin
            e7_2_reg  <= e7_c;
            e15_2_reg <= gf_mul(e7_c, e8_c);
        end
        if (rdy3) begin
            e7_3_reg  <= e7_2_reg;
            e60_3_reg <= gf_mul(e30_c, e30_c);
        end
        if (rdy4) begin
            e127_4_reg <= gf_mul(e60_3_reg, e67_c);
        end
    end

    assign out_beat.valid = v4_reg;
    assign out_beat.data  = e127_4_reg;

    // Input is refused only when every stage is occupied.
    `ASSERT_IMPL(a_full_when_stalled, aclk, aresetn, !in_ready,
                 v1_reg && v2_reg && v3_reg && v4_reg)
    // A beat held at the last stage stays, with its value.
    `ASSERT_NEXT(a_last_holds, aclk, aresetn, v4_reg && !out_ready,
                 v4_reg && $stable(e127_4_reg))
    // An occupied stage that cannot drain keeps its beat.
    `ASSERT_NEXT(a_mid_holds, aclk, aresetn, v2_reg && !rdy3,
                 v2_reg && $stable(e15_2_reg) && $stable(e7_2_reg))

endmodule

>>> hdl/aesgf_affine_stage.sv
module aesgf_affine_stage
    import aesgf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_beat_t in_beat,
    output logic       in_ready,
    output logic       out_valid,
    output gf_byte_t   out_data,
    input  logic       out_ready
);

    logic     out_valid_reg, out_valid_next;
    gf_byte_t out_data_reg;
    gf_byte_t inv_c;

    // The output register takes a beat when empty or being drained.
    assign in_ready       = !out_valid_reg || out_ready;
    assign out_valid_next = in_ready ? in_beat.valid : out_valid_reg;

    // Final squaring gives the inverse, then the affine map.
    assign inv_c = gf_mul(in_beat.data, in_beat.data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            out_data_reg <= aes_affine(inv_c);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> bench/tb_aes_sbox_gf_inverse_unit.sv
`timescale 1ns / 100ps

module tb_aes_sbox_gf_inverse_unit;
    import aesgf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 690;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SQUEEZE_AT   = 400;
    localparam int SQUEEZE_LEN  = 200;

    // One expected substitution, kept with its source byte for reporting.
    typedef struct {
        gf_byte_t in_byte;
        gf_byte_t sub_byte;
    } sbox_pair_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    gf_byte_t   pending_bytes[$];
    sbox_pair_t expected_subs[$];

    logic in_fire;
    int   in_count;
    int   idle_cycles;
    int   mismatches;
    int   tx_gap;
    int   tx_calm;
    int   rx_hold;
    int   rx_calm;
    bit   squeeze_done;

    aes_sbox_gf_inverse_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Field product, least significant bit of b first.
    function automatic gf_byte_t field_times(input gf_byte_t a, input gf_byte_t b);
        gf_byte_t acc;
        gf_byte_t run;
        acc = '0;
        run = a;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                acc = acc ^ run;
            end
            run = run[BYTE_W-1] ? ({run[BYTE_W-2:0], 1'b0} ^ REDUCE_CONST)
                                : {run[BYTE_W-2:0], 1'b0};
        end
        return acc;
    endfunction

    // S-box value: v^254 by square and multiply, then the affine map bit by bit.
    function automatic gf_byte_t sbox_of(input gf_byte_t v);
        gf_byte_t inv;
        gf_byte_t sq;
        gf_byte_t res;
        int       e;
        inv = 8'h01;
        sq  = v;
        e   = 254;
        while (e != 0) begin
            if (e[0]) begin
                inv = field_times(inv, sq);
            end
            sq = field_times(sq, sq);
            e  = e >> 1;
        end
        for (int i = 0; i < BYTE_W; i++) begin
            res[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
                   ^ inv[(i + 7) % 8] ^ AFFINE_CONST[i];
        end
        return res;
    endfunction

    // Gap length in cycles: mostly none, sometimes short, rarely long.
    function automatic int draw_gap(input int pct_idle);
        int r;
        r = $urandom_range(0, 99);
        if (r >= pct_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Record accepted input beats and check accepted output beats.
    always @(posedge aclk) begin
        sbox_pair_t want;
        if (!aresetn) begin
            in_fire     <= 1'b0;
            in_count    <= 0;
            idle_cycles <= 0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                want.in_byte  = s_tdata;
                want.sub_byte = sbox_of(s_tdata);
                expected_subs.push_back(want);
                in_count <= in_count + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_subs.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, actual %02h",
                             $realtime, m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_subs.pop_front();
                    if (m_tdata !== want.sub_byte) begin
                        $display("%0t: sub_byte of %02h: expected %02h, actual %02h",
                                 $realtime, want.in_byte, want.sub_byte, m_tdata);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Input driver: offers the next pending byte once the previous beat went through.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes.pop_front();
                if (tx_calm > 0) begin
                    tx_calm = tx_calm - 1;
                end else begin
                    tx_gap = draw_gap(35);
                    if ($urandom_range(0, 49) == 0) begin
                        tx_calm = $urandom_range(30, 90);
                    end
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, calm stretches and one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!squeeze_done && in_count >= SQUEEZE_AT) begin
            squeeze_done = 1'b1;
            rx_hold = SQUEEZE_LEN;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm = rx_calm - 1;
            end else begin
                rx_hold = draw_gap(25);
                if ($urandom_range(0, 99) == 0) begin
                    rx_calm = $urandom_range(40, 120);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        gf_byte_t sweep[256];
        int       j;
        gf_byte_t t;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        mismatches   = 0;
        tx_gap       = 0;
        tx_calm      = 0;
        rx_hold      = 0;
        rx_calm      = 0;
        squeeze_done = 1'b0;

        // Directed bytes: zero, which has no inverse, the extremes and known S-box pairs.
        pending_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h02, 8'h03, 8'h55,
                          8'hAA, 8'h53, 8'hCA, 8'h10, 8'h63, 8'hFE, 8'h8D, 8'h00};

        // Every byte value once, in shuffled order.
        for (int i = 0; i < 256; i++) begin
            sweep[i] = gf_byte_t'(i);
        end
        for (int i = 255; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = sweep[i];
            sweep[i] = sweep[j];
            sweep[j] = t;
        end
        for (int i = 0; i < 256; i++) begin
            pending_bytes.push_back(sweep[i]);
        end

        // Random bytes, with zero and all-ones mixed in now and then.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 19))
                0:       pending_bytes.push_back(8'h00);
                1:       pending_bytes.push_back(8'hFF);
                default: pending_bytes.push_back(gf_byte_t'($urandom_range(0, 255)));
            endcase
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (!(pending_bytes.size() == 0 && !s_tvalid && expected_subs.size() == 0)
               && idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        if (idle_cycles < STALL_LIMIT) begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end

        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     expected_subs.size());
            $display("** aes_sbox_gf_inverse_unit: FAILED **");
        end else if (mismatches == 0 && expected_subs.size() == 0) begin
            $display("** aes_sbox_gf_inverse_unit: PASSED **");
        end else begin
            $display("** aes_sbox_gf_inverse_unit: FAILED **");
        end
        $finish;
    end

endmodule
